// ===== src/brsp_pkg.sv =====
package brsp_pkg;

  // Result kinds
  localparam logic KIND_BASE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Decoded bases
  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;
  localparam logic [2:0] BASE_N = 3'd4;

  // Record status codes
  localparam logic [2:0] ST_MEASURED  = 3'd0;
  localparam logic [2:0] ST_NO_SEQ    = 3'd1;
  localparam logic [2:0] ST_SECONDARY = 3'd2;
  localparam logic [2:0] ST_HARD_CLIP = 3'd3;
  localparam logic [2:0] ST_MALFORMED = 3'd4;

  // Error kinds
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_SIZE    = 3'd1;
  localparam logic [2:0] ERR_LENGTHS = 3'd2;
  localparam logic [2:0] ERR_NAME    = 3'd3;
  localparam logic [2:0] ERR_CIGAR   = 3'd4;
  localparam logic [2:0] ERR_SEQ     = 3'd5;
  localparam logic [2:0] ERR_FIELDS  = 3'd6;
  localparam logic [2:0] ERR_UNTERM  = 3'd7;

  // CIGAR op code for a hard clip
  localparam logic [3:0] CIGAR_HARD_CLIP = 4'd5;

  // Reset value of the largest accepted block size
  localparam logic [30:0] MAX_SIZE_RESET = 31'h1000_0000;

  typedef struct packed {
    logic        kind;
    logic [2:0]  base;
    logic [27:0] base_position;
    logic [2:0]  record_status;
    logic [2:0]  error_kind;
    logic        reverse_strand;
    logic [28:0] sequence_length;
    logic        last;
  } res_t;

  // Map a 4-bit SEQ code to a base
  function automatic logic [2:0] decode_base(input logic [3:0] code);
    logic [2:0] res;
    case (code)
      4'd1:    res = BASE_A;
      4'd2:    res = BASE_C;
      4'd4:    res = BASE_G;
      4'd8:    res = BASE_T;
      default: res = BASE_N;
    endcase
    return res;
  endfunction

  // Saturate a 31-bit length to the 29-bit result field
  function automatic logic [28:0] sat_len(input logic [30:0] len);
    logic [28:0] res;
    res = (len[30:29] != 2'b00) ? 29'h1FFF_FFFF : len[28:0];
    return res;
  endfunction

endpackage

// ===== src/bam_record_sequence_parser_top.sv =====
// Channel  | Handshake               | Payload
// ---------+-------------------------+--------------------------------------------
// input    | in_valid_i / in_ready_o | data_byte_i
// output   | out_valid_o/out_ready_i | kind_o, base_o, base_position_o, ...,last_o
// config   | cfg_we_i                | cfg_wdata_i (largest block size)
//
// Each byte is parsed in the cycle it is accepted and its 0..2 results are
// written to a 4-entry result queue; a byte can be taken every cycle while the
// queue holds at most two results, so the input stalls while the sink takes
// results slower than they are written. Layout bound checks are spread over the
// name-length, CIGAR-count and sequence-length bytes. Reset clears the parser,
// the queue and the halt; the size limit returns to 256 MiB. After a malformed
// record the block keeps taking bytes but drops them until reset.
module bam_record_sequence_parser_top
  import brsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [2:0]  base_o,
  output logic [27:0] base_position_o,
  output logic [2:0]  record_status_o,
  output logic [2:0]  error_kind_o,
  output logic        reverse_strand_o,
  output logic [28:0] sequence_length_o,
  output logic        last_o
);

  // Parser state
  logic [30:0] max_q;
  logic [1:0]  hdr_q, hdr_d;
  logic        body_q, body_d;
  logic [30:0] p_q, p_d;
  logic [30:0] rs_q, rs_d;
  logic [30:0] lastp_q, lastp_d;
  logic [7:0]  nl_q, nl_d;
  logic [15:0] cc_q, cc_d;
  logic        rev_q, rev_d;
  logic        sec_q, sec_d;
  logic [30:0] sl_q, sl_d;
  logic        clip_q, clip_d;
  logic [2:0]  pend_q, pend_d;
  logic [30:0] rema_q, rema_d;
  logic [30:0] remb_q, remb_d;
  logic [18:0] s0_q, s0_d;
  logic [18:0] lastop_q, lastop_d;
  logic [27:0] pos_q, pos_d;
  logic [30:0] left_q, left_d;
  logic        halted_q, halted_d;

  // Result queue
  res_t        mem_q [4];
  logic [1:0]  wr_q, rd_q;
  logic [2:0]  cnt_q;

  logic        in_accept, out_pop;
  logic [1:0]  n_res;
  res_t        res_w [2];
  logic        fail;
  logic [2:0]  fail_code;

  // Datapath helpers
  logic [7:0]  b;
  logic [30:0] full_size;
  logic        size_bad;
  logic [31:0] diffa, diffb;
  logic [17:0] cc4;
  logic [8:0]  c0;
  logic [18:0] s0_sum;
  logic [30:0] sl_new;
  logic [32:0] fields_need;
  logic        p_ge32, name_end, clip_hit, seq_hit;
  logic [27:0] pos_p1, pos_p2;
  logic [2:0]  st;
  res_t        fail_res, stat_res;

  assign b          = data_byte_i;
  assign in_ready_o = (cnt_q <= 3'd2);
  assign in_accept  = in_valid_i & in_ready_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_pop    = out_valid_o & out_ready_i;

  // Block size check at the fourth size byte
  assign full_size = {b[6:0], rs_q[23:0]};
  assign size_bad  = b[7] || ((b == 8'd0) && (rs_q[23:5] == 19'd0)) || (full_size > max_q);

  // Remaining space after the fixed part and the name, then after the CIGAR ops
  assign diffa  = {1'b0, rs_q} - 32'd32 - {24'd0, nl_q};
  assign cc4    = {cc_q, 2'b00};
  assign diffb  = {1'b0, rema_q} - {14'd0, cc4};
  assign c0     = 9'd32 + {1'b0, nl_q};
  assign s0_sum = {10'd0, c0} + {1'b0, cc4};

  // Packed SEQ plus QUAL space: sl + ceil(sl / 2)
  assign sl_new      = {b[6:0], sl_q[23:0]};
  assign fields_need = {2'b00, sl_new} + {3'b000, sl_new[30:1]} + {32'd0, sl_new[0]};

  assign p_ge32   = (p_q[30:5] != 26'd0);
  assign name_end = (p_q == {22'd0, c0} - 31'd1);
  assign clip_hit = (cc_q != 16'd0) && (b[3:0] == CIGAR_HARD_CLIP) &&
                    ((p_q == {22'd0, c0}) || (p_q == {12'd0, lastop_q}));
  assign seq_hit  = (p_q >= {12'd0, s0_q}) && (left_q != 31'd0);

  assign pos_p1 = (pos_q == 28'hFFF_FFFF) ? pos_q : pos_q + 28'd1;
  assign pos_p2 = (pos_p1 == 28'hFFF_FFFF) ? pos_p1 : pos_p1 + 28'd1;

  // End-of-record status, clip seen on this byte included
  always_comb begin
    if (sl_q == 31'd0) begin
      st = ST_NO_SEQ;
    end else if (sec_q) begin
      st = ST_SECONDARY;
    end else if (clip_d) begin
      st = ST_HARD_CLIP;
    end else begin
      st = ST_MEASURED;
    end
  end

  always_comb begin
    fail_res = '0;
    fail_res.kind          = KIND_STATUS;
    fail_res.record_status = ST_MALFORMED;
    fail_res.error_kind    = fail_code;
    fail_res.last          = 1'b1;
    stat_res = '0;
    stat_res.kind            = KIND_STATUS;
    stat_res.record_status   = st;
    stat_res.error_kind      = ERR_NONE;
    stat_res.reverse_strand  = rev_q;
    stat_res.sequence_length = sat_len(sl_q);
  end

  // Parse one byte
  always_comb begin
    hdr_d    = hdr_q;
    body_d   = body_q;
    p_d      = p_q;
    rs_d     = rs_q;
    lastp_d  = lastp_q;
    nl_d     = nl_q;
    cc_d     = cc_q;
    rev_d    = rev_q;
    sec_d    = sec_q;
    sl_d     = sl_q;
    clip_d   = clip_q;
    pend_d   = pend_q;
    rema_d   = rema_q;
    remb_d   = remb_q;
    s0_d     = s0_q;
    lastop_d = lastop_q;
    pos_d    = pos_q;
    left_d   = left_q;
    halted_d = halted_q;
    n_res    = 2'd0;
    res_w[0] = '0;
    res_w[1] = '0;
    fail     = 1'b0;
    fail_code = ERR_NONE;

    if (in_accept && !halted_q) begin
      if (!body_q) begin
        // Collect the little-endian block size
        case (hdr_q)
          2'd0: rs_d[7:0]   = b;
          2'd1: rs_d[15:8]  = b;
          2'd2: rs_d[23:16] = b;
          default: begin
            rs_d[30:24] = b[6:0];
            lastp_d     = full_size - 31'd1;
            body_d      = 1'b1;
            p_d         = 31'd0;
            if (size_bad) begin
              fail      = 1'b1;
              fail_code = ERR_SIZE;
            end
          end
        endcase
        hdr_d = hdr_q + 2'd1;
      end else begin
        // Capture the fixed fields and run the layout checks
        case (p_q)
          31'd8:  nl_d = b;
          31'd9: begin
            rema_d = diffa[30:0];
            if (diffa[31]) begin
              pend_d = ERR_NAME;
            end
          end
          31'd12: cc_d = {8'd0, b};
          31'd13: cc_d[15:8] = b;
          31'd14: begin
            rev_d    = b[4];
            remb_d   = diffb[30:0];
            s0_d     = s0_sum;
            lastop_d = s0_sum - 19'd4;
            if (diffb[31] && (pend_q == ERR_NONE)) begin
              pend_d = ERR_CIGAR;
            end
          end
          31'd15: sec_d = b[0] | b[3];
          31'd16: sl_d[7:0]   = b;
          31'd17: sl_d[15:8]  = b;
          31'd18: sl_d[23:16] = b;
          31'd19: begin
            sl_d   = sl_new;
            left_d = sl_new;
            pos_d  = 28'd0;
            clip_d = 1'b0;
            if ((nl_q == 8'd0) || b[7]) begin
              fail      = 1'b1;
              fail_code = ERR_LENGTHS;
            end else if (pend_q != ERR_NONE) begin
              fail      = 1'b1;
              fail_code = pend_q;
            end else if ({1'b0, sl_new} > {remb_q, 1'b0}) begin
              fail      = 1'b1;
              fail_code = ERR_SEQ;
            end else if (fields_need > {2'b00, remb_q}) begin
              fail      = 1'b1;
              fail_code = ERR_FIELDS;
            end
          end
          default: ;
        endcase

        if (p_ge32 && name_end && (b != 8'd0)) begin
          fail      = 1'b1;
          fail_code = ERR_UNTERM;
        end else begin
          if (p_ge32 && clip_hit) begin
            clip_d = 1'b1;
          end
          // Emit one or two bases from the packed byte
          if (p_ge32 && seq_hit) begin
            res_w[0] = '0;
            res_w[0].kind            = KIND_BASE;
            res_w[0].base            = decode_base(b[7:4]);
            res_w[0].base_position   = pos_q;
            res_w[0].reverse_strand  = rev_q;
            res_w[0].sequence_length = sat_len(sl_q);
            if (left_q[30:1] != 30'd0) begin
              res_w[1] = res_w[0];
              res_w[1].base          = decode_base(b[3:0]);
              res_w[1].base_position = pos_p1;
              n_res  = 2'd2;
              left_d = left_q - 31'd2;
              pos_d  = pos_p2;
            end else begin
              n_res  = 2'd1;
              left_d = left_q - 31'd1;
              pos_d  = pos_p1;
            end
          end
          // Close the record at its last byte
          if (p_q == lastp_q) begin
            if (n_res == 2'd0) begin
              res_w[0] = stat_res;
            end else begin
              res_w[1] = stat_res;
            end
            n_res  = n_res + 2'd1;
            body_d = 1'b0;
            hdr_d  = 2'd0;
            p_d    = 31'd0;
          end else begin
            p_d = p_q + 31'd1;
          end
        end
      end

      if (fail) begin
        halted_d = 1'b1;
        n_res    = 2'd1;
        res_w[0] = fail_res;
        res_w[1] = '0;
      end
    end

    // Mark the last result of the byte
    res_w[0].last = (n_res == 2'd1);
    res_w[1].last = 1'b1;
  end

  // Hold parser control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= MAX_SIZE_RESET;
      hdr_q    <= 2'd0;
      body_q   <= 1'b0;
      p_q      <= 31'd0;
      clip_q   <= 1'b0;
      pend_q   <= ERR_NONE;
      pos_q    <= 28'd0;
      left_q   <= 31'd0;
      halted_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      hdr_q    <= hdr_d;
      body_q   <= body_d;
      p_q      <= p_d;
      clip_q   <= clip_d;
      pend_q   <= (body_d || !body_q) ? pend_d : ERR_NONE;
      pos_q    <= pos_d;
      left_q   <= left_d;
      halted_q <= halted_d;
    end
  end

  // Hold record fields
  always_ff @(posedge clk_i) begin
    rs_q     <= rs_d;
    lastp_q  <= lastp_d;
    nl_q     <= nl_d;
    cc_q     <= cc_d;
    rev_q    <= rev_d;
    sec_q    <= sec_d;
    sl_q     <= sl_d;
    rema_q   <= rema_d;
    remb_q   <= remb_d;
    s0_q     <= s0_d;
    lastop_q <= lastop_d;
  end

  // Advance queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_q + n_res;
      rd_q  <= rd_q + {1'b0, out_pop};
      cnt_q <= cnt_q + {1'b0, n_res} - {2'b00, out_pop};
    end
  end

  // Write results into the queue
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      mem_q[wr_q] <= res_w[0];
    end
    if (n_res == 2'd2) begin
      mem_q[wr_q + 2'd1] <= res_w[1];
    end
  end

  // Present the head result
  always_comb begin
    kind_o            = mem_q[rd_q].kind;
    base_o            = mem_q[rd_q].base;
    base_position_o   = mem_q[rd_q].base_position;
    record_status_o   = mem_q[rd_q].record_status;
    error_kind_o      = mem_q[rd_q].error_kind;
    reverse_strand_o  = mem_q[rd_q].reverse_strand;
    sequence_length_o = mem_q[rd_q].sequence_length;
    last_o            = mem_q[rd_q].last;
  end

`ifndef SYNTHESIS
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("result queue overflow");

  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt released without reset");

  a_halt_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> (n_res == 2'd0)) else $error("result written while halted");

  a_pair_bases : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_res == 2'd2) |-> (res_w[0].kind == KIND_BASE) && (res_w[1].kind == KIND_BASE))
    else $error("status shares a byte with two bases");
`endif

endmodule
